[rtl/core/bia_pkg.sv]
`timescale 1ns / 1ps
package bia_pkg;

   localparam int WORD_W = 64;
   localparam int BIT_W  = 6;

   localparam logic [1:0] FUNC_ALLOC = 2'd0;
   localparam logic [1:0] FUNC_FREE  = 2'd1;
   localparam logic [1:0] FUNC_INIT  = 2'd2;
   localparam logic [1:0] FUNC_NOP   = 2'd3;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_RANGE = 2'd2;

   localparam logic [2:0] CSR_BASE_ID    = 3'd0;
   localparam logic [2:0] CSR_NUM_IDS    = 3'd1;
   localparam logic [2:0] CSR_RESERVED   = 3'd2;
   localparam logic [2:0] CSR_RAND_MODE  = 3'd3;
   localparam logic [2:0] CSR_KEEP_EMPTY = 3'd4;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_ALLOC_WR,
      S_FREE_CHK,
      S_FREE_WR,
      S_INIT_SET,
      S_INIT_WR
   } bia_state_type;

   typedef enum logic [1:0] {
      RSP_NONE,
      RSP_ALLOC,
      RSP_FULL,
      RSP_RANGE
   } rsp_kind_type;

   typedef struct packed {
      logic         req_load;
      logic         ptr_start;
      logic         ptr_zero;
      logic         rd_issue;
      logic         from_zero;
      logic         hit_capture;
      logic         alloc_commit;
      logic         free_rd;
      logic         free_commit;
      logic         init_start;
      logic         init_wr;
      logic         rsp_en;
      rsp_kind_type rsp_kind;
   } bia_cmd_type;

   typedef struct packed {
      logic chk_vld;
      logic hit;
      logic last;
      logic free_in_range;
      logic sweep_last;
   } bia_stat_type;

   // bits set where base + bit index < lim
   function automatic logic [WORD_W-1:0] low_mask(input logic [31:0] base,
                                                  input logic [31:0] lim);
      logic [31:0]       d;
      logic [WORD_W-1:0] m;
      d = lim - base;
      if (lim <= base) begin
         m = '0;
      end else if (d >= 32'(WORD_W)) begin
         m = '1;
      end else begin
         m = (WORD_W'(1) << d[BIT_W-1:0]) - WORD_W'(1);
      end
      return m;
   endfunction

   // index of the lowest set bit
   function automatic logic [BIT_W-1:0] first_set(input logic [WORD_W-1:0] v);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = BIT_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

[rtl/core/bia_ram.sv]
`timescale 1ns / 1ps
module bia_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/bia_ctrl.sv]
`timescale 1ns / 1ps
module bia_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [1:0]            req_func,
   input  bia_pkg::bia_stat_type stat,
   output bia_pkg::bia_cmd_type  cmd,
   output logic                  busy
);

   bia_pkg::bia_state_type state_ff, state_in;
   logic                   phase2_ff, phase2_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= bia_pkg::S_CLEAR;
         phase2_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         phase2_ff <= phase2_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      phase2_in     = phase2_ff;
      cmd           = '0;
      cmd.rsp_kind  = bia_pkg::RSP_NONE;
      cmd.from_zero = phase2_ff;
      unique case (state_ff)
         bia_pkg::S_CLEAR: begin
            // map wipe after reset, no response
            cmd.init_wr = 1'b1;
            if (stat.sweep_last) begin
               state_in = bia_pkg::S_IDLE;
            end
         end
         bia_pkg::S_IDLE: begin
            if (start) begin
               cmd.req_load = 1'b1;
               unique case (req_func)
                  bia_pkg::FUNC_ALLOC: begin
                     cmd.ptr_start = 1'b1;
                     phase2_in     = 1'b0;
                     state_in      = bia_pkg::S_SCAN;
                  end
                  bia_pkg::FUNC_FREE: state_in = bia_pkg::S_FREE_CHK;
                  bia_pkg::FUNC_INIT: state_in = bia_pkg::S_INIT_SET;
                  default: begin
                     cmd.rsp_en   = 1'b1;
                     cmd.rsp_kind = bia_pkg::RSP_NONE;
                  end
               endcase
            end
         end
         bia_pkg::S_SCAN: begin
            // one word read issued per cycle, except while the scan restarts from word zero, checked the cycle after
            cmd.rd_issue = 1'b1;
            if (stat.chk_vld && stat.hit) begin
               cmd.rd_issue    = 1'b0;
               cmd.hit_capture = 1'b1;
               state_in        = bia_pkg::S_ALLOC_WR;
            end else if (stat.chk_vld && stat.last) begin
               cmd.rd_issue = 1'b0;
               if (!phase2_ff) begin
                  cmd.ptr_zero = 1'b1;
                  phase2_in    = 1'b1;
               end else begin
                  cmd.rsp_en   = 1'b1;
                  cmd.rsp_kind = bia_pkg::RSP_FULL;
                  state_in     = bia_pkg::S_IDLE;
               end
            end
         end
         bia_pkg::S_ALLOC_WR: begin
            cmd.alloc_commit = 1'b1;
            cmd.rsp_en       = 1'b1;
            cmd.rsp_kind     = bia_pkg::RSP_ALLOC;
            state_in         = bia_pkg::S_IDLE;
         end
         bia_pkg::S_FREE_CHK: begin
            if (stat.free_in_range) begin
               cmd.free_rd = 1'b1;
               state_in    = bia_pkg::S_FREE_WR;
            end else begin
               cmd.rsp_en   = 1'b1;
               cmd.rsp_kind = bia_pkg::RSP_RANGE;
               state_in     = bia_pkg::S_IDLE;
            end
         end
         bia_pkg::S_FREE_WR: begin
            cmd.free_commit = 1'b1;
            cmd.rsp_en      = 1'b1;
            cmd.rsp_kind    = bia_pkg::RSP_NONE;
            state_in        = bia_pkg::S_IDLE;
         end
         bia_pkg::S_INIT_SET: begin
            cmd.init_start = 1'b1;
            state_in       = bia_pkg::S_INIT_WR;
         end
         bia_pkg::S_INIT_WR: begin
            cmd.init_wr = 1'b1;
            if (stat.sweep_last) begin
               cmd.rsp_en   = 1'b1;
               cmd.rsp_kind = bia_pkg::RSP_NONE;
               state_in     = bia_pkg::S_IDLE;
            end
         end
         default: state_in = bia_pkg::S_IDLE;
      endcase
   end

   assign busy = (state_ff != bia_pkg::S_IDLE);

endmodule

[rtl/core/bia_dp.sv]
`timescale 1ns / 1ps
module bia_dp #(
   parameter int MAX_SLOTS = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bia_pkg::bia_cmd_type  cmd,
   output bia_pkg::bia_stat_type stat,
   input  logic [31:0]           req_free_id,
   input  logic [3:0]            req_random_skip,
   input  logic                  csr_wr_en,
   input  logic [2:0]            csr_index,
   input  logic [31:0]           csr_wr_data,
   output logic                  rsp_valid,
   output logic [31:0]           rsp_alloc_id,
   output logic [1:0]            rsp_status
);

   localparam int WORD_W = bia_pkg::WORD_W;
   localparam int BIT_W  = bia_pkg::BIT_W;
   localparam int NWORDS = (MAX_SLOTS + WORD_W - 1) / WORD_W;
   localparam int WI_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int SLOT_W = $clog2(MAX_SLOTS);
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);

   // configuration
   logic [31:0] base_id_ff;
   logic [10:0] num_ids_ff;
   logic [10:0] reserved_ff;
   logic        random_mode_ff;
   logic        keep_empty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_id_ff     <= '0;
         num_ids_ff     <= 11'd1024;
         reserved_ff    <= '0;
         random_mode_ff <= 1'b0;
         keep_empty_ff  <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            bia_pkg::CSR_BASE_ID:    base_id_ff     <= csr_wr_data;
            bia_pkg::CSR_NUM_IDS:    num_ids_ff     <= csr_wr_data[10:0];
            bia_pkg::CSR_RESERVED:   reserved_ff    <= csr_wr_data[10:0];
            bia_pkg::CSR_RAND_MODE:  random_mode_ff <= csr_wr_data[0];
            bia_pkg::CSR_KEEP_EMPTY: keep_empty_ff  <= csr_wr_data[0];
            default: ;
         endcase
      end
   end

   // effective slot count
   logic [CNT_W-1:0] n_eff;
   logic [31:0]      n32;
   assign n_eff = (32'(num_ids_ff) > 32'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
                                                     : CNT_W'(num_ids_ff);
   assign n32   = 32'(n_eff);

   // request capture
   logic [31:0] free_id_ff;
   logic [3:0]  skip_ff;

   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         free_id_ff <= req_free_id;
         skip_ff    <= req_random_skip;
      end
   end

   // map memory
   logic              ram_we;
   logic [WI_W-1:0]   ram_waddr;
   logic [WORD_W-1:0] ram_wdata;
   logic              ram_re;
   logic [WI_W-1:0]   ram_raddr;
   logic [WORD_W-1:0] ram_rdata;

   bia_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NWORDS),
      .AW    (WI_W)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // scan pointer and read tracking
   logic [WI_W-1:0]   scan_ptr_ff;
   logic              rd_vld_ff;
   logic [WI_W-1:0]   rd_tag_ff;
   logic [SLOT_W-1:0] next_search_ff, next_search_in;
   logic [CNT_W-1:0]  res_lim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ptr_ff <= '0;
         rd_vld_ff   <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.rd_issue;
         if (cmd.ptr_start) begin
            scan_ptr_ff <= WI_W'(next_search_ff >> BIT_W);
         end else if (cmd.ptr_zero || cmd.init_start) begin
            scan_ptr_ff <= '0;
         end else if (cmd.rd_issue || cmd.init_wr) begin
            scan_ptr_ff <= scan_ptr_ff + WI_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_issue) begin
         rd_tag_ff <= scan_ptr_ff;
      end
   end

   // word check
   logic [31:0]       tag_base32;
   logic [31:0]       from32;
   logic [WORD_W-1:0] free_vec;
   logic [BIT_W-1:0]  hit_bit;

   assign tag_base32 = 32'(rd_tag_ff) << BIT_W;
   assign from32     = cmd.from_zero ? 32'd0 : 32'(next_search_ff);
   assign free_vec   = ~ram_rdata
                     & ~bia_pkg::low_mask(tag_base32, from32)
                     & bia_pkg::low_mask(tag_base32, n32);
   assign hit_bit    = bia_pkg::first_set(free_vec);

   logic [WORD_W-1:0] hit_word_ff;
   logic [WI_W-1:0]   hit_addr_ff;
   logic [SLOT_W-1:0] hit_slot_ff;

   always_ff @(posedge clock) begin
      if (cmd.hit_capture) begin
         hit_word_ff <= ram_rdata | (WORD_W'(1) << hit_bit);
         hit_addr_ff <= rd_tag_ff;
         hit_slot_ff <= SLOT_W'({rd_tag_ff, hit_bit});
      end
   end

   // free address
   logic [31:0]      free_slot32;
   logic [WI_W-1:0]  free_word;
   logic [BIT_W-1:0] free_bit;

   assign free_slot32 = free_id_ff - base_id_ff;
   assign free_word   = WI_W'(free_slot32 >> BIT_W);
   assign free_bit    = free_slot32[BIT_W-1:0];

   // next search position
   logic [31:0] adv32;
   assign adv32 = random_mode_ff ? (32'(next_search_ff) + 32'(skip_ff))
                                 : (32'(hit_slot_ff) + 32'd1);

   always_comb begin
      next_search_in = next_search_ff;
      if (cmd.alloc_commit) begin
         next_search_in = (adv32 >= n32) ? '0 : SLOT_W'(adv32);
      end else if (cmd.init_start) begin
         next_search_in = random_mode_ff ? SLOT_W'(skip_ff) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_search_ff <= '0;
         res_lim_ff     <= '0;
      end else begin
         next_search_ff <= next_search_in;
         if (cmd.init_start) begin
            if (keep_empty_ff) begin
               res_lim_ff <= '0;
            end else if (32'(reserved_ff) < n32) begin
               res_lim_ff <= CNT_W'(reserved_ff);
            end else begin
               res_lim_ff <= n_eff;
            end
         end
      end
   end

   // memory port muxing
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = scan_ptr_ff;
      ram_wdata = bia_pkg::low_mask(32'(scan_ptr_ff) << BIT_W, 32'(res_lim_ff));
      if (cmd.alloc_commit) begin
         ram_we    = 1'b1;
         ram_waddr = hit_addr_ff;
         ram_wdata = hit_word_ff;
      end else if (cmd.free_commit) begin
         ram_we    = 1'b1;
         ram_waddr = free_word;
         ram_wdata = ram_rdata & ~(WORD_W'(1) << free_bit);
      end else if (cmd.init_wr) begin
         ram_we = 1'b1;
      end
   end

   assign ram_re    = cmd.rd_issue | cmd.free_rd;
   assign ram_raddr = cmd.free_rd ? free_word : scan_ptr_ff;

   // status to controller
   always_comb begin
      stat               = '0;
      stat.chk_vld       = rd_vld_ff;
      stat.hit           = rd_vld_ff & (|free_vec);
      stat.last          = rd_vld_ff & ((tag_base32 + 32'(WORD_W)) >= n32);
      stat.free_in_range = (free_slot32 < n32);
      stat.sweep_last    = (scan_ptr_ff == WI_W'(NWORDS - 1));
   end

   // response
   logic        rsp_valid_ff;
   logic [31:0] rsp_alloc_id_ff;
   logic [1:0]  rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.rsp_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_en) begin
         case (cmd.rsp_kind)
            bia_pkg::RSP_ALLOC: begin
               rsp_alloc_id_ff <= base_id_ff + 32'(hit_slot_ff);
               rsp_status_ff   <= bia_pkg::STAT_OK;
            end
            bia_pkg::RSP_FULL: begin
               rsp_alloc_id_ff <= '1;
               rsp_status_ff   <= bia_pkg::STAT_FULL;
            end
            bia_pkg::RSP_RANGE: begin
               rsp_alloc_id_ff <= '1;
               rsp_status_ff   <= bia_pkg::STAT_RANGE;
            end
            default: begin
               rsp_alloc_id_ff <= '1;
               rsp_status_ff   <= bia_pkg::STAT_OK;
            end
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_alloc_id = rsp_alloc_id_ff;
   assign rsp_status   = rsp_status_ff;

endmodule

[rtl/core/bitmap_id_allocator.sv]
`timescale 1ns / 1ps
// allocate: one 64-bit map word read per cycle through the single map read port, except
//   while the scan restarts from word zero; two passes over the map at most
// free: read-modify-write of one map word when the id is in range; init: rewrites every map word
// one request at a time; start is taken again in the cycle the response shows
// reset: synchronous; busy stays high while the map is wiped
// results are strobed for one cycle on rsp_valid; the receiver cannot stall
module bitmap_id_allocator #(
   parameter int MAX_SLOTS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_free_id,
   input  logic [3:0]  req_random_skip,
   output logic        rsp_valid,
   output logic [31:0] rsp_alloc_id,
   output logic [1:0]  rsp_status,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wr_data
);

   bia_pkg::bia_cmd_type  cmd;
   bia_pkg::bia_stat_type stat;

   bia_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_func),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   bia_dp #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_free_id     (req_free_id),
      .req_random_skip (req_random_skip),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_alloc_id    (rsp_alloc_id),
      .rsp_status      (rsp_status)
   );

endmodule

[rtl/core/bia_checker.sv]
`timescale 1ns / 1ps
module bia_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [1:0]  req_func,
   input logic        rsp_valid,
   input logic [31:0] rsp_alloc_id,
   input logic [1:0]  rsp_status
);

   // a real request makes busy high in the cycle after it is taken
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_func != bia_pkg::FUNC_NOP) |=> busy)
      else $error("busy low right after a request was taken");

   // unused function answers at once with no id
   a_nop_reply: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_func == bia_pkg::FUNC_NOP) |=>
         rsp_valid && (rsp_status == bia_pkg::STAT_OK) && (rsp_alloc_id == 32'hFFFF_FFFF))
      else $error("unused function not answered in the next cycle");

   // failures never carry an id
   a_no_id_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != bia_pkg::STAT_OK) |-> (rsp_alloc_id == 32'hFFFF_FFFF))
      else $error("error response carries an id");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == bia_pkg::STAT_OK) || (rsp_status == bia_pkg::STAT_FULL)
                    || (rsp_status == bia_pkg::STAT_RANGE))
      else $error("undefined status code");

endmodule

bind bitmap_id_allocator bia_checker u_bia_checker (.*);
